// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PFA_ASSERT_SAME(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pfa check failed");

// next-cycle implication, checked out of reset
`define PFA_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pfa check failed");

`endif

// ===== src/pfa_pkg.sv =====
package pfa_pkg;

    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int WORD_W     = 64;
    localparam int WSEL_W     = $clog2(WORD_W);
    localparam int WADDR_W    = IDX_W - WSEL_W;
    localparam int WORDS      = NUM_PAGES / WORD_W;
    localparam int CHUNK_W    = 8;
    localparam int CHUNKS     = WORD_W / CHUNK_W;
    localparam int CSEL_W     = $clog2(CHUNKS);
    localparam int CPOP_W     = $clog2(CHUNK_W) + 1;
    localparam int AW         = 32;
    localparam int EXT_W      = AW + 2;
    localparam int CIDX_W     = 2;

    localparam logic [2:0] FN_INIT       = 3'd0;
    localparam logic [2:0] FN_ALLOC_ONE  = 3'd1;
    localparam logic [2:0] FN_ALLOC_RUN  = 3'd2;
    localparam logic [2:0] FN_FREE_ONE   = 3'd3;
    localparam logic [2:0] FN_FREE_RUN   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [2:0] MD_INIT  = 3'd0;
    localparam logic [2:0] MD_SCAN  = 3'd1;
    localparam logic [2:0] MD_CLEAR = 3'd2;
    localparam logic [2:0] MD_FREE  = 3'd3;
    localparam logic [2:0] MD_BAD   = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_RAM_BASE     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ALLOC_FLOOR  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RESERVE_LOW  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_RESERVE_HIGH = 2'd3;

    localparam logic [AW-1:0] RAM_BASE_RST    = 32'h8000_0000;
    localparam logic [AW-1:0] ALLOC_FLOOR_RST = 32'h8000_0000;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] address;
        logic [15:0] page_count;
    } pfa_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page_address;
        logic [15:0] free_pages;
    } pfa_rsp_t;

    typedef struct packed {
        logic       load;
        logic       setup;
        logic       start_walk;
        logic       rd;
        logic       load_word;
        logic       chunk;
        logic       wr;
        logic       next_word;
        logic       to_clear;
        logic       clr_wr;
        logic       finish;
        logic [1:0] status;
    } pfa_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       bad_n;
        logic       empty;
        logic       last_word;
        logic       last_chunk;
        logic       found;
        logic       any_new;
    } pfa_stat_t;

    function automatic cnt_t clamp_cnt(input logic [EXT_W-1:0] v);
        return (v > EXT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : v[CNT_W-1:0];
    endfunction

    function automatic cnt_t ceil_idx(input logic [AW:0] a, input logic [AW-1:0] base);
        logic [EXT_W-1:0] d;
        d = EXT_W'(a) - EXT_W'(base) + EXT_W'(PAGE_BYTES - 1);
        if (a <= {1'b0, base})
        begin
            return '0;
        end
        return clamp_cnt(d >> PAGE_SHIFT);
    endfunction

endpackage

// ===== src/page_frame_allocator.sv =====
// one item at a time; the free map is walked in 64-bit words, each in the steps
// (read, read wait, eight 8-bit chunk steps, write back, which a scan skips)
// init: walks the whole map; alloc: scans for the run, then clears the words it spans
// free: ends at the check step when ignored up front, else walks each word touched
// the result strobe is registered after the last step; the receiver cannot stall
// after reset a pass over all 512 words zeroes the map; busy stays high until it ends
module page_frame_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfa_pkg::pfa_req_t req,
    output logic              done,
    output pfa_pkg::pfa_rsp_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import pfa_pkg::*;
    `include "assert_macros.svh"

    pfa_cmd_t  cmd;
    pfa_stat_t stat;

    pfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pfa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    `PFA_ASSERT_SAME(a_done_idle, done, !busy)
    `PFA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `PFA_ASSERT_SAME(a_fail_no_addr, done && result.status != ST_OK, result.page_address == '0)
    `PFA_ASSERT_SAME(a_count_range, done, 32'(result.free_pages) <= NUM_PAGES)
endmodule

// ===== src/pfa_ram.sv =====
module pfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== src/pfa_datapath.sv =====
module pfa_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfa_pkg::pfa_req_t      req,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  pfa_pkg::pfa_cmd_t      cmd,
    output pfa_pkg::pfa_stat_t     stat,
    output logic                   done,
    output pfa_pkg::pfa_rsp_t      result
);
    import pfa_pkg::*;

    logic [AW-1:0]      ram_base_reg, alloc_floor_reg, reserve_low_reg, reserve_high_reg;
    pfa_req_t           req_reg;
    logic [15:0]        n_reg;
    logic [2:0]         mode_reg, mode_next;
    cnt_t               lo_reg, lo_next, hi_reg, hi_next, rl_reg, rh_reg;
    logic               ract_reg;
    logic [WADDR_W-1:0] waddr_reg, waddr_next;
    logic [CSEL_W-1:0]  csel_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [WORD_W-1:0]  rdata;
    cnt_t               run_reg, run_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic               any_reg;
    cnt_t               total_reg;
    pfa_rsp_t           rsp_reg;
    logic               done_reg;

    logic [AW:0]          fa, fa_al, rh_raw, rh_al, lim_raw;
    logic [AW-1:0]        rlo_al;
    cnt_t                 lim;
    logic signed [EXT_W-1:0] diff, dsh, endv;
    cnt_t                 lo_f, hi_f, hi_e;
    logic                 aligned;
    cnt_t                 hm1, s_idx;
    logic [WADDR_W-1:0]   last_w;
    logic [IDX_W-1:0]     bidx;
    logic [CHUNK_W-1:0]   old_c, new_c;
    logic [CPOP_W-1:0]    pop;
    logic [2:0]           mode_ld;
    logic [15:0]          n_ld;

    always_comb
    begin
        fa      = (AW+1)'(alloc_floor_reg) + (AW+1)'(PAGE_BYTES - 1);
        fa_al   = {fa[AW:PAGE_SHIFT], PAGE_SHIFT'(0)};
        rh_raw  = (AW+1)'(reserve_high_reg) + (AW+1)'(PAGE_BYTES - 1);
        rh_al   = {rh_raw[AW:PAGE_SHIFT], PAGE_SHIFT'(0)};
        rlo_al  = {reserve_low_reg[AW-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
        lim_raw = {1'b1, AW'(0)} - {1'b0, ram_base_reg};
        lim     = clamp_cnt(EXT_W'(lim_raw >> PAGE_SHIFT));

        aligned = (req_reg.address[PAGE_SHIFT-1:0] == '0)
                && (ram_base_reg[PAGE_SHIFT-1:0] == '0);
        diff = $signed(EXT_W'(req_reg.address)) - $signed(EXT_W'(ram_base_reg));
        dsh  = diff >>> PAGE_SHIFT;
        endv = dsh + $signed(EXT_W'(n_reg));
        lo_f = (dsh < 0) ? '0 : clamp_cnt(dsh);
        hi_e = (endv <= 0) ? '0 : clamp_cnt(endv);
        hi_f = (hi_e < lim) ? hi_e : lim;
    end

    // command loading
    always_comb
    begin
        case (req.func)
            FN_INIT:                   mode_ld = MD_INIT;
            FN_ALLOC_ONE, FN_ALLOC_RUN: mode_ld = MD_SCAN;
            FN_FREE_ONE, FN_FREE_RUN:   mode_ld = MD_FREE;
            default:                   mode_ld = MD_BAD;
        endcase
        n_ld = (req.func == FN_ALLOC_ONE || req.func == FN_FREE_ONE) ? 16'd1 : req.page_count;
    end

    always_comb
    begin
        hm1    = hi_reg - cnt_t'(1);
        last_w = (mode_reg == MD_INIT || mode_reg == MD_SCAN) ? '1
               : hm1[IDX_W-1:WSEL_W];
        s_idx  = cnt_t'(end_reg) + cnt_t'(1) - cnt_t'(n_reg);
    end

    // one chunk of the current word
    always_comb
    begin
        cnt_t i;
        logic inr, inres;
        bidx       = {waddr_reg, csel_reg, (WSEL_W-CSEL_W)'(0)};
        old_c      = word_reg[csel_reg*CHUNK_W +: CHUNK_W];
        new_c      = old_c;
        pop        = '0;
        run_next   = run_reg;
        found_next = found_reg;
        end_next   = end_reg;
        for (int j = 0; j < CHUNK_W; j++)
        begin
            i     = cnt_t'(bidx) + cnt_t'(j);
            inr   = (i >= lo_reg) && (i < hi_reg);
            inres = ract_reg && (i >= rl_reg) && (i < rh_reg);
            case (mode_reg)
                MD_INIT:
                begin
                    new_c[j] = inr && !inres;
                    pop      = pop + CPOP_W'(new_c[j]);
                end
                MD_FREE:
                begin
                    new_c[j] = old_c[j] | inr;
                    pop      = pop + CPOP_W'(inr && !old_c[j]);
                end
                MD_CLEAR:
                begin
                    new_c[j] = old_c[j] && !inr;
                end
                MD_SCAN:
                begin
                    if (!found_next)
                    begin
                        if (old_c[j])
                        begin
                            run_next = run_next + cnt_t'(1);
                            if (run_next == cnt_t'(n_reg))
                            begin
                                found_next = 1'b1;
                                end_next   = i[IDX_W-1:0];
                            end
                        end
                        else
                        begin
                            run_next = '0;
                        end
                    end
                end
                default:
                begin
                    new_c[j] = old_c[j];
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        waddr_next = waddr_reg;
        if (cmd.load)
        begin
            mode_next = mode_ld;
        end
        if (cmd.setup)
        begin
            case (mode_reg)
                MD_INIT:
                begin
                    lo_next = ceil_idx(fa_al, ram_base_reg);
                    hi_next = lim;
                end
                MD_FREE:
                begin
                    lo_next = aligned ? lo_f : '0;
                    hi_next = aligned ? hi_f : '0;
                end
                default:
                begin
                    lo_next = '0;
                    hi_next = CNT_W'(NUM_PAGES);
                end
            endcase
        end
        if (cmd.start_walk)
        begin
            waddr_next = (mode_reg == MD_FREE) ? lo_reg[IDX_W-1:WSEL_W] : '0;
        end
        if (cmd.next_word)
        begin
            waddr_next = waddr_reg + WADDR_W'(1);
        end
        if (cmd.to_clear)
        begin
            mode_next  = MD_CLEAR;
            lo_next    = s_idx;
            hi_next    = cnt_t'(end_reg) + cnt_t'(1);
            waddr_next = s_idx[IDX_W-1:WSEL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_base_reg     <= RAM_BASE_RST;
            alloc_floor_reg  <= ALLOC_FLOOR_RST;
            reserve_low_reg  <= '0;
            reserve_high_reg <= '0;
            mode_reg         <= MD_INIT;
            waddr_reg        <= '0;
            csel_reg         <= '0;
            found_reg        <= 1'b0;
            any_reg          <= 1'b0;
            total_reg        <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RAM_BASE:     ram_base_reg     <= cfg_data;
                    CFG_ALLOC_FLOOR:  alloc_floor_reg  <= cfg_data;
                    CFG_RESERVE_LOW:  reserve_low_reg  <= cfg_data;
                    CFG_RESERVE_HIGH: reserve_high_reg <= cfg_data;
                    default:          ram_base_reg     <= ram_base_reg;
                endcase
            end
            mode_reg  <= mode_next;
            waddr_reg <= waddr_next;
            done_reg  <= cmd.finish;
            if (cmd.setup && mode_reg == MD_INIT)
            begin
                total_reg <= '0;
            end
            if (cmd.start_walk)
            begin
                found_reg <= 1'b0;
                any_reg   <= 1'b0;
            end
            if (cmd.load_word)
            begin
                csel_reg <= '0;
            end
            if (cmd.chunk)
            begin
                csel_reg  <= csel_reg + CSEL_W'(1);
                found_reg <= found_next;
                if (mode_reg == MD_INIT || mode_reg == MD_FREE)
                begin
                    total_reg <= total_reg + cnt_t'(pop);
                end
                if (mode_reg == MD_FREE && pop != '0)
                begin
                    any_reg <= 1'b1;
                end
            end
            if (cmd.to_clear)
            begin
                total_reg <= total_reg - cnt_t'(n_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            n_reg   <= n_ld;
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.setup)
        begin
            rl_reg   <= ceil_idx({1'b0, rlo_al}, ram_base_reg);
            rh_reg   <= ceil_idx(rh_al, ram_base_reg);
            ract_reg <= (rlo_al != '0);
        end
        if (cmd.start_walk)
        begin
            run_reg <= '0;
        end
        if (cmd.load_word)
        begin
            word_reg <= rdata;
        end
        if (cmd.chunk)
        begin
            word_reg[csel_reg*CHUNK_W +: CHUNK_W] <= new_c;
            run_reg <= run_next;
            end_reg <= end_next;
        end
        if (cmd.finish)
        begin
            rsp_reg.status       <= cmd.status;
            rsp_reg.page_address <= (cmd.status == ST_OK && mode_reg == MD_CLEAR)
                ? ram_base_reg + (AW'(lo_reg) << PAGE_SHIFT) : '0;
            rsp_reg.free_pages   <= 16'(total_reg);
        end
    end

    pfa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_map (
        .clk   (clk),
        .we    (cmd.wr | cmd.clr_wr),
        .waddr (waddr_reg),
        .wdata (cmd.clr_wr ? '0 : word_reg),
        .re    (cmd.rd),
        .raddr (waddr_reg),
        .rdata (rdata)
    );

    assign stat.mode       = mode_reg;
    assign stat.bad_n      = (n_reg == '0) || (32'(n_reg) > NUM_PAGES);
    assign stat.empty      = (hi_reg <= lo_reg);
    assign stat.last_word  = (waddr_reg == last_w);
    assign stat.last_chunk = (csel_reg == '1);
    assign stat.found      = found_reg;
    assign stat.any_new    = any_reg;
    assign done            = done_reg;
    assign result          = rsp_reg;
endmodule

// ===== src/pfa_ctrl.sv =====
module pfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pfa_pkg::pfa_stat_t stat,
    output pfa_pkg::pfa_cmd_t  cmd
);
    import pfa_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_WAIT  = 4'd5;
    localparam logic [3:0] S_CHUNK = 4'd6;
    localparam logic [3:0] S_WR    = 4'd7;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.last_word)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.next_word = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                case (stat.mode)
                    MD_INIT:
                    begin
                        cmd.start_walk = 1'b1;
                        state_next     = S_RD;
                    end
                    MD_SCAN:
                    begin
                        if (stat.bad_n)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_FAIL;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = S_RD;
                        end
                    end
                    MD_FREE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_IGNORED;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = S_RD;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_FAIL;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                cmd.load_word = 1'b1;
                state_next    = S_CHUNK;
            end
            S_CHUNK:
            begin
                cmd.chunk = 1'b1;
                if (stat.last_chunk)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                if (stat.mode == MD_SCAN)
                begin
                    if (stat.found)
                    begin
                        cmd.to_clear = 1'b1;
                        state_next   = S_RD;
                    end
                    else if (stat.last_word)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_FAIL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_word = 1'b1;
                        state_next    = S_RD;
                    end
                end
                else
                begin
                    cmd.wr = 1'b1;
                    if (stat.last_word)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = (stat.mode == MD_FREE && !stat.any_new)
                            ? ST_IGNORED : ST_OK;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_word = 1'b1;
                        state_next    = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule
